// ===== rtl/drgt_pkg.sv =====
package drgt_pkg;

  localparam int unsigned COORD_W  = 12;
  localparam int unsigned RADIUS_W = 11;
  localparam int unsigned NUM_REGS = 8;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned CFG_IDX_W = 4;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_START_LEFT   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_START_TOP    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_START_WIDTH  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_HEIGHT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_END_LEFT     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_END_TOP      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_END_WIDTH    = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_END_HEIGHT   = 3'd7;

  localparam logic [COORD_W-1:0] REG_RESET [NUM_REGS] = '{
    12'd150, 12'd150, 12'd150, 12'd150, 12'd10, 12'd10, 12'd150, 12'd150
  };

  // Majority threshold: 100 * hits > 79 * fill
  localparam int unsigned RATIO_NUM = 100;
  localparam int unsigned RATIO_DEN = 79;

  typedef enum logic [1:0] {
    MODE_WAITING   = 2'd0,
    MODE_RECORDING = 2'd1,
    MODE_FINISHED  = 2'd2
  } mode_t;

  // Window entry flags
  typedef struct packed {
    logic in_end;
    logic in_start;
  } flags_t;

  // Item handed from the window stage to the mode stage
  typedef struct packed {
    logic                present;
    logic                evict;
    flags_t              flags;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [RADIUS_W-1:0] r;
  } item_t;

  function automatic logic circle_inside(
    input logic [COORD_W-1:0]  x,
    input logic [COORD_W-1:0]  y,
    input logic [RADIUS_W-1:0] r,
    input logic [COORD_W-1:0]  left,
    input logic [COORD_W-1:0]  top,
    input logic [COORD_W-1:0]  width,
    input logic [COORD_W-1:0]  height
  );
    logic [COORD_W:0] xr_lo, xr_hi, yr_lo, yr_hi, right, bottom;
    // x - r >= left  <=>  x >= left + r
    xr_lo  = {1'b0, left} + {2'b0, r};
    xr_hi  = {1'b0, x} + {2'b0, r};
    yr_lo  = {1'b0, top} + {2'b0, r};
    yr_hi  = {1'b0, y} + {2'b0, r};
    right  = {1'b0, left} + {1'b0, width};
    bottom = {1'b0, top} + {1'b0, height};
    return ({1'b0, x} >= xr_lo) && (xr_hi <= right) &&
           ({1'b0, y} >= yr_lo) && (yr_hi <= bottom);
  endfunction

endpackage

// ===== rtl/drgt_flag_ram.sv =====
module drgt_flag_ram import drgt_pkg::*; #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic          clk,
  input  logic          en,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  flags_t        wdata,
  output flags_t        rdata
);

  flags_t mem [DEPTH];

  // Read-first: the old entry comes out while the new one goes in
  always_ff @(posedge clk) begin
    if (en) begin
      rdata <= mem[addr];
      if (we) begin
        mem[addr] <= wdata;
      end
    end
  end

endmodule

// ===== rtl/drgt_mode_ctrl.sv =====
module drgt_mode_ctrl import drgt_pkg::*; #(
  parameter int unsigned CW = 5
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  item_t         item,
  input  logic [CW-1:0] fill,
  input  flags_t        old_flags,
  output mode_t         mode_after,
  output logic          recorded
);

  localparam int unsigned PW = CW + 7;

  mode_t         mode, mode_next;
  logic [CW-1:0] start_hits, end_hits;
  logic [CW-1:0] start_next, end_next;
  logic [PW-1:0] fill_scaled, start_scaled, end_scaled;
  logic          start_major, end_major;

  always_comb begin
    start_next = start_hits
               + CW'(item.present & item.flags.in_start)
               - CW'(item.evict & old_flags.in_start);
    end_next   = end_hits
               + CW'(item.present & item.flags.in_end)
               - CW'(item.evict & old_flags.in_end);
    fill_scaled  = PW'(fill) * PW'(RATIO_DEN);
    start_scaled = PW'(start_next) * PW'(RATIO_NUM);
    end_scaled   = PW'(end_next) * PW'(RATIO_NUM);
    // An empty window has zero hits, so it never passes
    start_major  = start_scaled > fill_scaled;
    end_major    = end_scaled > fill_scaled;
  end

  always_comb begin
    mode_next = mode;
    recorded  = 1'b0;
    unique case (mode)
      MODE_WAITING: begin
        if (start_major) begin
          mode_next = MODE_RECORDING;
        end
      end
      MODE_RECORDING: begin
        recorded = item.present;
        if (end_major) begin
          mode_next = MODE_FINISHED;
        end
      end
      MODE_FINISHED: begin
        mode_next = MODE_FINISHED;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  assign mode_after = mode_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_WAITING;
      start_hits <= '0;
      end_hits   <= '0;
    end else if (advance) begin
      mode       <= mode_next;
      start_hits <= start_next;
      end_hits   <= end_next;
    end
  end

endmodule

// ===== rtl/dwell_region_gesture_tracker_top.sv =====
// An accepted input word is registered in stage s1, then in the master-side result word.
// Throughput: one word per cycle unless the master side stalls. The flag RAM is read, and
// written for a present blob, at the write slot in the accept cycle; hit counts and mode
// update as the item leaves stage s1. Reset (rst, synchronous): mode waiting, window empty,
// counts zero, rectangle registers to their defaults. Flag RAM contents are not cleared;
// entries are used only after being written.
module dwell_region_gesture_tracker_top import drgt_pkg::*; #(
  parameter int unsigned WINDOW_DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data,
  // Input blob stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [39:0]          s_tdata,  // blob_x[11:0], blob_y[23:12], blob_radius[34:24]
  input  logic                 s_tuser,  // present
  // Result stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [39:0]          m_tdata,  // mode[1:0], point_x[13:2], point_y[25:14],
                                         // point_radius[36:26]
  output logic                 m_tuser   // recorded
);

  localparam int unsigned CW = $clog2(WINDOW_DEPTH + 1);
  localparam int unsigned AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam logic [CW-1:0] FULL      = CW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

  logic [COORD_W-1:0] regs [NUM_REGS];

  logic [COORD_W-1:0]  in_x, in_y;
  logic [RADIUS_W-1:0] in_r;
  logic                in_accept;
  flags_t              in_flags;

  logic [AW-1:0] write_slot;
  logic [CW-1:0] fill_count;
  logic          window_full;

  logic          s1_valid;
  item_t         s1_item;
  logic [CW-1:0] s1_fill;
  logic          s1_advance;
  flags_t        old_flags;

  mode_t mode_after;
  logic  recorded;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= REG_RESET;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      regs[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign in_x = s_tdata[11:0];
  assign in_y = s_tdata[23:12];
  assign in_r = s_tdata[34:24];

  assign s1_advance = s1_valid && (!m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign in_accept  = s_tvalid && s_tready;

  assign window_full = (fill_count == FULL);

  always_comb begin
    in_flags.in_start = circle_inside(in_x, in_y, in_r,
                                      regs[REG_START_LEFT], regs[REG_START_TOP],
                                      regs[REG_START_WIDTH], regs[REG_START_HEIGHT]);
    in_flags.in_end   = circle_inside(in_x, in_y, in_r,
                                      regs[REG_END_LEFT], regs[REG_END_TOP],
                                      regs[REG_END_WIDTH], regs[REG_END_HEIGHT]);
  end

  // Read the entry at the write slot, and write the new one for a present blob, in the accept cycle
  drgt_flag_ram #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_flag_ram (
    .clk   (clk),
    .en    (in_accept),
    .we    (s_tuser),
    .addr  (write_slot),
    .wdata (in_flags),
    .rdata (old_flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      fill_count <= '0;
    end else if (in_accept && s_tuser) begin
      write_slot <= (write_slot == LAST_SLOT) ? '0 : write_slot + AW'(1);
      if (!window_full) begin
        fill_count <= fill_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.present <= s_tuser;
      s1_item.evict   <= s_tuser && window_full;
      s1_item.flags   <= in_flags;
      s1_item.x       <= in_x;
      s1_item.y       <= in_y;
      s1_item.r       <= in_r;
      s1_fill         <= (s_tuser && !window_full) ? fill_count + CW'(1) : fill_count;
    end
  end

  drgt_mode_ctrl #(
    .CW (CW)
  ) u_mode_ctrl (
    .clk        (clk),
    .rst        (rst),
    .advance    (s1_advance),
    .item       (s1_item),
    .fill       (s1_fill),
    .old_flags  (old_flags),
    .mode_after (mode_after),
    .recorded   (recorded)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      m_tuser <= recorded;
      m_tdata <= {3'b0,
                  recorded ? s1_item.r : {RADIUS_W{1'b0}},
                  recorded ? s1_item.y : {COORD_W{1'b0}},
                  recorded ? s1_item.x : {COORD_W{1'b0}},
                  mode_after};
    end
  end

endmodule

// ===== dv/tb_dwell_region_gesture_tracker_top.sv =====
module tb_dwell_region_gesture_tracker_top;
  import drgt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WINDOW_DEPTH = 16;
  localparam int unsigned STALL_LIMIT  = 3000;
  localparam int unsigned LONG_HOLD    = 80;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned COORD_MAX    = (1 << COORD_W) - 1;
  localparam int unsigned RADIUS_MAX   = (1 << RADIUS_W) - 1;

  // Indexes past the register file; writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] IDX_BEYOND_LO = 4'd8;
  localparam logic [CFG_IDX_W-1:0] IDX_BEYOND_HI = 4'd15;

  typedef struct packed {
    logic                present;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [RADIUS_W-1:0] r;
  } blob_t;

  typedef struct packed {
    mode_t               mode;
    logic                recorded;
    logic [COORD_W-1:0]  px;
    logic [COORD_W-1:0]  py;
    logic [RADIUS_W-1:0] pr;
  } gesture_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COORD_W-1:0]   cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [39:0]          s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [39:0]          m_tdata;
  logic                 m_tuser;

  dwell_region_gesture_tracker_top #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker shadow state
  logic [COORD_W-1:0] rect_reg [NUM_REGS];
  mode_t              trk_mode;
  flags_t             trk_flags [WINDOW_DEPTH];
  int unsigned        trk_fill, trk_slot, trk_start_hits, trk_end_hits;

  blob_t        blob_q [$];
  gesture_out_t gesture_out_q [$];

  int unsigned n_fail, n_blobs, n_points, n_writes;
  int unsigned hold_req, hold_ack, hold_left;
  int unsigned burst_left, gap_left;
  int unsigned pat_kind, pat_left;
  int unsigned idle_cycles;

  blob_t        in_blob;
  gesture_out_t want;

  function automatic bit fits_in(blob_t b, int left, int top, int wd, int ht);
    int x, y, r;
    x = b.x;
    y = b.y;
    r = b.r;
    return (x - r >= left) && (x + r <= left + wd) && (y - r >= top) && (y + r <= top + ht);
  endfunction

  function automatic bit over_share(int unsigned hits);
    return trk_fill != 0 && RATIO_NUM * hits > RATIO_DEN * trk_fill;
  endfunction

  function automatic gesture_out_t follow_gesture(blob_t b);
    flags_t       f, old;
    gesture_out_t o;
    o.recorded = 1'b0;
    o.px = '0;
    o.py = '0;
    o.pr = '0;
    if (b.present) begin
      f.in_start = fits_in(b, rect_reg[REG_START_LEFT], rect_reg[REG_START_TOP],
                           rect_reg[REG_START_WIDTH], rect_reg[REG_START_HEIGHT]);
      f.in_end = fits_in(b, rect_reg[REG_END_LEFT], rect_reg[REG_END_TOP],
                         rect_reg[REG_END_WIDTH], rect_reg[REG_END_HEIGHT]);
      // full window: the oldest entry leaves the counts
      if (trk_fill >= WINDOW_DEPTH) begin
        old = trk_flags[trk_slot];
        if (old.in_start) trk_start_hits--;
        if (old.in_end) trk_end_hits--;
      end else begin
        trk_fill++;
      end
      trk_flags[trk_slot] = f;
      if (f.in_start) trk_start_hits++;
      if (f.in_end) trk_end_hits++;
      trk_slot = (trk_slot + 1) % WINDOW_DEPTH;
    end
    case (trk_mode)
      MODE_WAITING: begin
        if (over_share(trk_start_hits)) trk_mode = MODE_RECORDING;
      end
      MODE_RECORDING: begin
        o.recorded = b.present;
        if (over_share(trk_end_hits)) trk_mode = MODE_FINISHED;
      end
      default: ;
    endcase
    o.mode = trk_mode;
    if (o.recorded) begin
      o.px = b.x;
      o.py = b.y;
      o.pr = b.r;
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      n_fail++;
    end
  endfunction

  // Sender: bursts of random length with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        s_tvalid <= 1'b0;
      end else if (blob_q.size() > 0) begin
        in_blob = blob_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, in_blob.r, in_blob.y, in_blob.x};
        s_tuser  <= in_blob.present;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall pattern of its own, plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_ack <= 0;
      hold_left <= 0;
      pat_kind <= 0;
      pat_left <= 0;
    end else if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= LONG_HOLD;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_kind <= $urandom_range(0, 3);
        pat_left <= $urandom_range(5, 40);
      end else begin
        pat_left <= pat_left - 1;
      end
      case (pat_kind)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (pat_left % 3 != 0);
      endcase
    end
  end

  // Predict on every accepted blob
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) begin
      in_blob.present = s_tuser;
      in_blob.x = s_tdata[11:0];
      in_blob.y = s_tdata[23:12];
      in_blob.r = s_tdata[34:24];
      gesture_out_q.push_back(follow_gesture(in_blob));
      n_blobs++;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (gesture_out_q.size() == 0) begin
        $error("result word with no blob pending");
        n_fail++;
      end else begin
        want = gesture_out_q.pop_front();
        check_field("mode", want.mode, m_tdata[1:0]);
        check_field("recorded", want.recorded, m_tuser);
        check_field("point_x", want.px, m_tdata[13:2]);
        check_field("point_y", want.py, m_tdata[25:14]);
        check_field("point_radius", want.pr, m_tdata[36:26]);
        if (m_tuser === 1'b1) n_points++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx < NUM_REGS) rect_reg[idx[REG_IDX_W-1:0]] = val;
    n_writes++;
  endtask

  task automatic set_rects(int sl, int st, int sw, int sh, int el, int et, int ew, int eh);
    write_reg(REG_START_LEFT, sl);
    write_reg(REG_START_TOP, st);
    write_reg(REG_START_WIDTH, sw);
    write_reg(REG_START_HEIGHT, sh);
    write_reg(REG_END_LEFT, el);
    write_reg(REG_END_TOP, et);
    write_reg(REG_END_WIDTH, ew);
    write_reg(REG_END_HEIGHT, eh);
  endtask

  // Hold until every blob is in and every result is out
  task automatic settle();
    do @(posedge clk); while (blob_q.size() != 0 || s_tvalid || gesture_out_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_blob(bit p, int x, int y, int r);
    blob_t b;
    b.present = p;
    b.x = x;
    b.y = y;
    b.r = r;
    blob_q.push_back(b);
  endtask

  function automatic int rand_coord();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return COORD_MAX;
      default: return $urandom_range(0, COORD_MAX);
    endcase
  endfunction

  function automatic blob_t any_blob(bit p);
    blob_t b;
    b.present = p;
    b.x = rand_coord();
    b.y = rand_coord();
    case ($urandom_range(0, 7))
      0: b.r = 0;
      1: b.r = RADIUS_MAX;
      2, 3: b.r = $urandom_range(0, RADIUS_MAX);
      default: b.r = $urandom_range(0, 200);
    endcase
    return b;
  endfunction

  function automatic blob_t inside_blob(int base);
    blob_t b;
    int left, top, wd, ht, lim, r, xlo, xhi, ylo, yhi;
    left = rect_reg[base];
    top  = rect_reg[base + 1];
    wd   = rect_reg[base + 2];
    ht   = rect_reg[base + 3];
    lim  = ((wd < ht) ? wd : ht) / 2;
    if (lim > RADIUS_MAX) lim = RADIUS_MAX;
    if ($urandom_range(0, 3) != 0 && lim > 60) lim = 60;
    r = $urandom_range(0, lim);
    xlo = left + r;
    xhi = left + wd - r;
    ylo = top + r;
    yhi = top + ht - r;
    if (xhi > COORD_MAX) xhi = COORD_MAX;
    if (yhi > COORD_MAX) yhi = COORD_MAX;
    if (xlo > xhi || ylo > yhi) return any_blob(1'b1);
    b.present = 1'b1;
    b.x = $urandom_range(xlo, xhi);
    b.y = $urandom_range(ylo, yhi);
    b.r = r;
    return b;
  endfunction

  task automatic push_mix(int n, int pct_start, int pct_end, int pct_gone, int pct_corner);
    int pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      if (pick < pct_start)
        blob_q.push_back(inside_blob(REG_START_LEFT));
      else if (pick < pct_start + pct_end)
        blob_q.push_back(inside_blob(REG_END_LEFT));
      else if (pick < pct_start + pct_end + pct_gone)
        blob_q.push_back(any_blob(1'b0));
      else if (pick < pct_start + pct_end + pct_gone + pct_corner)
        add_blob(1'b1, COORD_MAX, COORD_MAX, 0);
      else
        blob_q.push_back(any_blob(1'b1));
    end
  endtask

  initial begin
    for (int i = 0; i < NUM_REGS; i++) rect_reg[i] = REG_RESET[i];
    trk_mode = MODE_WAITING;
    trk_fill = 0;
    trk_slot = 0;
    trk_start_hits = 0;
    trk_end_hits = 0;
    n_fail = 0;
    n_blobs = 0;
    n_points = 0;
    n_writes = 0;
    hold_req = 0;
    idle_cycles = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Default rectangles: field extremes, edge-touching and one-pixel-out circles
    add_blob(1'b0, COORD_MAX, COORD_MAX, RADIUS_MAX);
    add_blob(1'b1, 0, 0, 0);
    add_blob(1'b1, COORD_MAX, COORD_MAX, RADIUS_MAX);
    add_blob(1'b1, 175, 175, 25);
    add_blob(1'b1, 275, 275, 25);
    add_blob(1'b1, 174, 200, 25);
    add_blob(1'b1, 276, 200, 25);
    add_blob(1'b1, 200, 174, 25);
    add_blob(1'b1, 35, 35, 25);
    add_blob(1'b1, 135, 135, 25);
    add_blob(1'b1, 136, 100, 25);
    add_blob(1'b1, 225, 225, 75);
    add_blob(1'b1, 225, 225, 76);
    add_blob(1'b0, 0, 0, 0);
    add_blob(1'b1, COORD_MAX, 0, RADIUS_MAX);
    add_blob(1'b1, 0, COORD_MAX, 0);
    add_blob(1'b1, 12'h555, 12'haaa, 11'h2aa);
    add_blob(1'b1, 12'haaa, 12'h555, 11'h555);
    add_blob(1'b1, 85, 85, 75);
    add_blob(1'b1, 85, 85, 76);
    settle();

    // Waiting: noise and broken runs toward the start rectangle
    set_rects(1000, 1200, 800, 600, 2500, 300, 700, 900);
    write_reg(IDX_BEYOND_LO, '1);
    push_mix(120, 35, 35, 15, 0);
    hold_req++;
    repeat (4) begin
      push_mix(10, 100, 0, 0, 0);
      push_mix(6, 0, 30, 30, 0);
    end
    push_mix(70, 35, 35, 15, 0);
    settle();

    // Whole canvas as start, single corner pixel as end: move into recording
    set_rects(0, 0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 0, 0);
    write_reg(IDX_BEYOND_HI, 12'h0a5);
    push_mix(20, 100, 0, 0, 0);
    push_mix(140, 60, 0, 15, 8);
    hold_req++;
    push_mix(20, 60, 0, 15, 8);
    settle();
    push_mix(120, 60, 0, 15, 8);
    settle();

    // Recording with rectangles at the other extremes
    set_rects(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1000, 1000, 1500, 1500);
    push_mix(200, 0, 30, 20, 20);
    settle();

    // Back to default rectangles: finish, then idle in finished
    set_rects(150, 150, 150, 150, 10, 10, 150, 150);
    push_mix(8, 0, 100, 0, 0);
    push_mix(6, 0, 0, 50, 0);
    push_mix(20, 0, 100, 0, 0);
    push_mix(100, 20, 30, 25, 5);
    settle();

    $display("Covered %0d blobs under five rectangle settings with %0d register writes.",
             n_blobs, n_writes);
    $display("%0d points recorded; tracker ended in mode %s.", n_points, trk_mode.name());
    if (n_fail == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
